/* design/mlpe_pkg.sv */
package mlpe_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int LEVEL_W    = 16;
	localparam int CLIP_W     = 32;
	localparam int GAIN_W     = 3;
	localparam int QSHIFT_W   = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int GAIN_MAX   = 7;
	localparam int DECAY_SHIFT = 5;

	localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sd32767;
	localparam logic signed [SAMPLE_W-1:0] OUT_MIN = -16'sd32768;

	localparam logic [GAIN_W-1:0]   GAIN_RESET   = 3'd1;
	localparam logic                MONO_RESET   = 1'b1;
	localparam logic [QSHIFT_W-1:0] QSHIFT_RESET = 4'd4;
	localparam logic [LEVEL_W-1:0]  QFLOOR_RESET = 16'd32;
	localparam logic [LEVEL_W-1:0]  QCEIL_RESET  = 16'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_SHIFT    = 3'd0,
		CFG_MONO_MODE     = 3'd1,
		CFG_QUIET_SHIFT   = 3'd2,
		CFG_QUIET_FLOOR   = 3'd3,
		CFG_QUIET_CEILING = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0]   gain_shift;
		logic                mono_mode;
		logic [QSHIFT_W-1:0] quiet_shift;
		logic [LEVEL_W-1:0]  quiet_floor;
		logic [LEVEL_W-1:0]  quiet_ceiling;
	} cfg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] quiet_level;
		logic [LEVEL_W-1:0] overall_peak;
		logic [CLIP_W-1:0]  clip_total;
	} levels_t;

endpackage

/* design/mlpe_if.sv */
interface mlpe_smp_if #(
	parameter int MIX_WIDTH = 24
);
	logic                        valid;
	logic                        ready;
	logic signed [MIX_WIDTH-1:0] mixed_left;
	logic signed [MIX_WIDTH-1:0] mixed_right;
	logic                        block_last;

	modport source(output valid, output mixed_left, output mixed_right, output block_last,
		input ready);
	modport sink(input valid, input mixed_left, input mixed_right, input block_last,
		output ready);
endinterface

interface mlpe_res_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [mlpe_pkg::SAMPLE_W-1:0]  out_left;
	logic signed [mlpe_pkg::SAMPLE_W-1:0]  out_right;
	logic                                  block_done;
	logic [mlpe_pkg::LEVEL_W-1:0]          quiet_level;
	logic [mlpe_pkg::LEVEL_W-1:0]          overall_peak;
	logic [mlpe_pkg::CLIP_W-1:0]           clip_total;

	modport source(output valid, output out_left, output out_right, output block_done,
		output quiet_level, output overall_peak, output clip_total, input ready);
	modport sink(input valid, input out_left, input out_right, input block_done,
		input quiet_level, input overall_peak, input clip_total, output ready);
endinterface

/* design/mlpe_gain_clamp.sv */
module mlpe_gain_clamp #(
	parameter int MIX_WIDTH = 24
) (
	input  logic signed [MIX_WIDTH-1:0]              sample,
	input  logic [mlpe_pkg::GAIN_W-1:0]              gain_shift,
	output logic signed [mlpe_pkg::SAMPLE_W-1:0]     clamped,
	output logic                                     clipped
);

	localparam int EXT_W = MIX_WIDTH + mlpe_pkg::GAIN_MAX;
	localparam logic signed [EXT_W-1:0] LIM_HI = EXT_W'(mlpe_pkg::OUT_MAX);
	localparam logic signed [EXT_W-1:0] LIM_LO = EXT_W'(mlpe_pkg::OUT_MIN);

	logic signed [EXT_W-1:0] ext;
	logic signed [EXT_W-1:0] shifted;
	logic                    over_hi;
	logic                    over_lo;

	assign ext     = EXT_W'(sample);
	assign shifted = ext <<< gain_shift;
	assign over_hi = shifted > LIM_HI;
	assign over_lo = shifted < LIM_LO;
	assign clipped = over_hi | over_lo;

	always_comb begin
		priority if (over_hi) begin
			clamped = mlpe_pkg::OUT_MAX;
		end else if (over_lo) begin
			clamped = mlpe_pkg::OUT_MIN;
		end else begin
			clamped = shifted[mlpe_pkg::SAMPLE_W-1:0];
		end
	end

endmodule

/* design/mlpe_level_track.sv */
module mlpe_level_track (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 advance,
	input  logic signed [mlpe_pkg::SAMPLE_W-1:0] left,
	input  logic                                 clip_l,
	input  logic                                 clip_r,
	input  logic                                 last,
	input  mlpe_pkg::cfg_t                       cfg,
	output mlpe_pkg::levels_t                    levels
);

	logic [mlpe_pkg::LEVEL_W-1:0] block_peak_q;
	logic [mlpe_pkg::LEVEL_W-1:0] envelope_q;
	logic [mlpe_pkg::LEVEL_W-1:0] max_peak_q;
	logic [mlpe_pkg::CLIP_W-1:0]  clip_count_q;
	logic [mlpe_pkg::LEVEL_W-1:0] quiet_q;

	logic signed [mlpe_pkg::SAMPLE_W:0] left_ext;
	logic [mlpe_pkg::SAMPLE_W:0]        mag_w;
	logic [mlpe_pkg::LEVEL_W-1:0]       mag;
	logic [mlpe_pkg::LEVEL_W-1:0]       peak_n;
	logic [mlpe_pkg::LEVEL_W-1:0]       max_n;
	logic [mlpe_pkg::LEVEL_W-1:0]       env_n;
	logic [mlpe_pkg::LEVEL_W-1:0]       shifted_env;
	logic [mlpe_pkg::LEVEL_W-1:0]       quiet_n;
	logic [mlpe_pkg::CLIP_W:0]          clip_sum;
	logic [mlpe_pkg::CLIP_W-1:0]        clip_n;

	assign left_ext = (mlpe_pkg::SAMPLE_W + 1)'(left);
	assign mag_w    = left_ext[mlpe_pkg::SAMPLE_W] ? (mlpe_pkg::SAMPLE_W + 1)'(-left_ext)
		: (mlpe_pkg::SAMPLE_W + 1)'(left_ext);
	assign mag      = mag_w[mlpe_pkg::LEVEL_W-1:0];
	assign peak_n   = (mag > block_peak_q) ? mag : block_peak_q;
	assign max_n    = (peak_n > max_peak_q) ? peak_n : max_peak_q;
	assign env_n    = (peak_n > envelope_q) ? peak_n
		: envelope_q - (envelope_q >> mlpe_pkg::DECAY_SHIFT);
	assign shifted_env = env_n >> cfg.quiet_shift;

	always_comb begin
		priority if (shifted_env < cfg.quiet_floor) begin
			quiet_n = cfg.quiet_floor;
		end else if (shifted_env > cfg.quiet_ceiling) begin
			quiet_n = cfg.quiet_ceiling;
		end else begin
			quiet_n = shifted_env;
		end
	end

	assign clip_sum = {1'b0, clip_count_q} + (mlpe_pkg::CLIP_W + 1)'(clip_l)
		+ (mlpe_pkg::CLIP_W + 1)'(clip_r);
	assign clip_n   = clip_sum[mlpe_pkg::CLIP_W] ? {mlpe_pkg::CLIP_W{1'b1}}
		: clip_sum[mlpe_pkg::CLIP_W-1:0];

	assign levels.quiet_level  = last ? quiet_n : quiet_q;
	assign levels.overall_peak = last ? max_n : max_peak_q;
	assign levels.clip_total   = clip_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_peak_q <= '0;
			envelope_q   <= '0;
			max_peak_q   <= '0;
			clip_count_q <= '0;
			quiet_q      <= '0;
		end else if (advance) begin
			clip_count_q <= clip_n;
			if (last) begin
				block_peak_q <= '0;
				envelope_q   <= env_n;
				max_peak_q   <= max_n;
				quiet_q      <= quiet_n;
			end else begin
				block_peak_q <= peak_n;
			end
		end
	end

endmodule

/* design/mix_limiter_peak_envelope_core.sv */
// Hard-clip limiter with block peak envelope.
//
// samples: one stereo mixer sample per transfer (mixed_left, mixed_right,
//   block_last marking the final sample of a block).
// results: one result per sample: gained and clamped out_left/out_right,
//   block_done, and the level readings quiet_level, overall_peak and
//   clip_total as they stand after that sample.
// cfg_we/cfg_index/cfg_data: register writes, taken in the cycle they are
//   presented; write only while no sample is in flight.
// Path: a taken sample passes the input register, then the result register,
//   before it is offered on results.
// Throughput: one sample per cycle while results.ready is high, set by the
//   single pass of clamp and level logic between the two registers.
// Stall: while results.ready is low the result holds; one more sample can
//   sit in the input register, after which samples.ready drops.
// Reset: clears both stages, all level state and the counter, and loads
//   the register defaults (gain 1, mono, quiet shift 4, floor 32,
//   ceiling 256).
module mix_limiter_peak_envelope_core #(
	parameter int MIX_WIDTH = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mlpe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mlpe_pkg::CFG_DATA_W-1:0]    cfg_data,
	mlpe_smp_if.sink                           samples,
	mlpe_res_if.source                         results
);

	mlpe_pkg::cfg_t    cfg_q;
	mlpe_pkg::levels_t levels;

	logic                                 valid_s1;
	logic signed [MIX_WIDTH-1:0]          left_s1;
	logic signed [MIX_WIDTH-1:0]          right_s1;
	logic                                 last_s1;

	logic                                 valid_s2;
	logic signed [mlpe_pkg::SAMPLE_W-1:0] left_s2;
	logic signed [mlpe_pkg::SAMPLE_W-1:0] right_s2;
	logic                                 done_s2;
	mlpe_pkg::levels_t                    levels_s2;

	logic                                 s2_free;
	logic                                 advance;
	logic                                 take_in;
	logic signed [mlpe_pkg::SAMPLE_W-1:0] left_c;
	logic signed [mlpe_pkg::SAMPLE_W-1:0] right_c;
	logic                                 clip_l;
	logic                                 clip_r_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_shift    <= mlpe_pkg::GAIN_RESET;
			cfg_q.mono_mode     <= mlpe_pkg::MONO_RESET;
			cfg_q.quiet_shift   <= mlpe_pkg::QSHIFT_RESET;
			cfg_q.quiet_floor   <= mlpe_pkg::QFLOOR_RESET;
			cfg_q.quiet_ceiling <= mlpe_pkg::QCEIL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mlpe_pkg::CFG_GAIN_SHIFT: begin
					cfg_q.gain_shift <= cfg_data[mlpe_pkg::GAIN_W-1:0];
				end
				mlpe_pkg::CFG_MONO_MODE: begin
					cfg_q.mono_mode <= cfg_data[0];
				end
				mlpe_pkg::CFG_QUIET_SHIFT: begin
					cfg_q.quiet_shift <= cfg_data[mlpe_pkg::QSHIFT_W-1:0];
				end
				mlpe_pkg::CFG_QUIET_FLOOR: begin
					cfg_q.quiet_floor <= cfg_data[mlpe_pkg::LEVEL_W-1:0];
				end
				mlpe_pkg::CFG_QUIET_CEILING: begin
					cfg_q.quiet_ceiling <= cfg_data[mlpe_pkg::LEVEL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign s2_free       = !valid_s2 || results.ready;
	assign advance       = valid_s1 && s2_free;
	assign samples.ready = !valid_s1 || s2_free;
	assign take_in       = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			left_s1  <= samples.mixed_left;
			right_s1 <= samples.mixed_right;
			last_s1  <= samples.block_last;
		end
	end

	mlpe_gain_clamp #(
		.MIX_WIDTH(MIX_WIDTH)
	) u_clamp_left (
		.sample     (left_s1),
		.gain_shift (cfg_q.gain_shift),
		.clamped    (left_c),
		.clipped    (clip_l)
	);

	mlpe_gain_clamp #(
		.MIX_WIDTH(MIX_WIDTH)
	) u_clamp_right (
		.sample     (right_s1),
		.gain_shift (cfg_q.gain_shift),
		.clamped    (right_c),
		.clipped    (clip_r_raw)
	);

	mlpe_level_track u_levels (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.left   (left_c),
		.clip_l (clip_l),
		.clip_r (clip_r_raw && !cfg_q.mono_mode),
		.last   (last_s1),
		.cfg    (cfg_q),
		.levels (levels)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			left_s2   <= left_c;
			right_s2  <= cfg_q.mono_mode ? left_c : right_c;
			done_s2   <= last_s1;
			levels_s2 <= levels;
		end
	end

	assign results.valid        = valid_s2;
	assign results.out_left     = left_s2;
	assign results.out_right    = right_s2;
	assign results.block_done   = done_s2;
	assign results.quiet_level  = levels_s2.quiet_level;
	assign results.overall_peak = levels_s2.overall_peak;
	assign results.clip_total   = levels_s2.clip_total;

endmodule

/* design/mlpe_checker.sv */
module mlpe_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [mlpe_pkg::SAMPLE_W-1:0] out_left,
	input logic signed [mlpe_pkg::SAMPLE_W-1:0] out_right,
	input logic                                 block_done,
	input logic [mlpe_pkg::LEVEL_W-1:0]         quiet_level,
	input logic [mlpe_pkg::LEVEL_W-1:0]         overall_peak,
	input logic [mlpe_pkg::CLIP_W-1:0]          clip_total
);

	logic                         xfer;
	logic [mlpe_pkg::LEVEL_W-1:0] quiet_prev_q;
	logic [mlpe_pkg::LEVEL_W-1:0] peak_prev_q;
	logic [mlpe_pkg::CLIP_W-1:0]  clip_prev_q;

	assign xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_prev_q <= '0;
			peak_prev_q  <= '0;
			clip_prev_q  <= '0;
		end else if (xfer) begin
			quiet_prev_q <= quiet_level;
			peak_prev_q  <= overall_peak;
			clip_prev_q  <= clip_total;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right)
			&& $stable(block_done) && $stable(quiet_level) && $stable(overall_peak)
			&& $stable(clip_total))
		else $error("result changed while stalled");

	a_clip_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		xfer |-> clip_total >= clip_prev_q)
		else $error("clip count went backward");

	a_peak_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		xfer |-> overall_peak >= peak_prev_q)
		else $error("overall peak went backward");

	a_levels_hold_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && !block_done |-> quiet_level == quiet_prev_q && overall_peak == peak_prev_q)
		else $error("levels changed inside a block");

endmodule

bind mix_limiter_peak_envelope_core mlpe_checker u_mlpe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.out_left     (results.out_left),
	.out_right    (results.out_right),
	.block_done   (results.block_done),
	.quiet_level  (results.quiet_level),
	.overall_peak (results.overall_peak),
	.clip_total   (results.clip_total)
);
